// ----- hdl/sse_data_line_extractor_assert.svh -----
// ---------------------------------------------------------------------------
// SSE data line extractor assertion macros
// Shorthand for clocked assertions with the block's clock and reset.
// ---------------------------------------------------------------------------
`ifndef SSE_DATA_LINE_EXTRACTOR_ASSERT_SVH
`define SSE_DATA_LINE_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SDLE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SDLE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sdle_pkg.sv -----
// ---------------------------------------------------------------------------
// SSE data line extractor package
// Shared constants, the result record and the prefix lookup.
// ---------------------------------------------------------------------------
package sdle_pkg;

    // Default line capacity; the store holds one byte less.
    localparam int LINE_CAP_DEF = 64;

    // Length of the "data:" field prefix.
    localparam int PREFIX_LEN = 5;

    // Byte codes the parser reacts to.
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_SPACE = 8'd32;

    // One result as it sits in the output queue.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       empty_event;
        logic       last_of_event;
    } result_t;

    // Expected byte of the "data:" prefix at a given position.
    function automatic logic [7:0] prefix_byte(input logic [2:0] pos);
        logic [7:0] val;
        case (pos)
            3'd0:    val = 8'h64;  // d
            3'd1:    val = 8'h61;  // a
            3'd2:    val = 8'h74;  // t
            3'd3:    val = 8'h61;  // a
            3'd4:    val = 8'h3a;  // :
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ----- hdl/sse_data_line_extractor.sv -----
// A plain byte is stored as it is taken; one request per cycle while not busy.
// A terminator that closes a data line stalls input while the payload is read
// out, one result per payload byte or an empty event; out_stall prolongs it.
// The first result follows the store read; then one per cycle unless out_stall.
// Reset clears the line length and the output queue; store contents stay undefined.
// ---------------------------------------------------------------------------
// SSE data line extractor
// Collects stream bytes into a line store and replays the payload of
// each "data:" line as a sequence of results.
// ---------------------------------------------------------------------------
module sse_data_line_extractor #(
    parameter int LINE_CAP = sdle_pkg::LINE_CAP_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] payload_byte,
    output logic       empty_event,
    output logic       last_of_event
);
    import sdle_pkg::*;

    localparam int DEPTH  = LINE_CAP - 1;
    localparam int LEN_W  = $clog2(LINE_CAP);
    localparam int ADDR_W = $clog2(DEPTH);

    logic [LEN_W-1:0] len_reg,    len_next;
    logic             pfx_ok_reg, pfx_ok_next;
    logic             space_reg,  space_next;

    logic             in_take;
    logic             is_term;
    logic             full;
    logic             wr_en;
    logic             is_data;
    logic             busy;
    logic             job_valid;
    logic             job_empty;
    logic [LEN_W-1:0] job_start;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]       rd_data;

    // Request decode.
    assign in_take = in_valid && !in_stall;
    assign is_term = (in_byte == BYTE_LF) || (in_byte == BYTE_CR);
    assign full    = len_reg == LEN_W'(DEPTH);
    assign wr_en   = in_take && !is_term && !full;
    assign in_stall = busy;

    // Line classification at the terminator.
    assign is_data   = (len_reg >= LEN_W'(PREFIX_LEN)) && pfx_ok_reg;
    assign job_start = ((len_reg > LEN_W'(PREFIX_LEN)) && space_reg)
                       ? LEN_W'(PREFIX_LEN + 1) : LEN_W'(PREFIX_LEN);
    assign job_empty = job_start >= len_reg;
    assign job_valid = in_take && is_term && is_data;

    // Line length and running prefix match.
    always_comb
    begin
        len_next    = len_reg;
        pfx_ok_next = pfx_ok_reg;
        space_next  = space_reg;
        if (in_take)
        begin
            if (is_term || full)
            begin
                len_next    = '0;
                pfx_ok_next = 1'b1;
                space_next  = 1'b0;
            end
            else
            begin
                len_next = len_reg + LEN_W'(1);
                if (len_reg < LEN_W'(PREFIX_LEN))
                begin
                    pfx_ok_next = pfx_ok_reg && (in_byte == prefix_byte(len_reg[2:0]));
                end
                if (len_reg == LEN_W'(PREFIX_LEN))
                begin
                    space_next = in_byte == BYTE_SPACE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            pfx_ok_reg <= 1'b1;
            space_reg  <= 1'b0;
        end
        else
        begin
            len_reg    <= len_next;
            pfx_ok_reg <= pfx_ok_next;
            space_reg  <= space_next;
        end
    end

    // Line store.
    sdle_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (in_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Payload replay and output queue.
    sdle_replay #(
        .LEN_W  (LEN_W),
        .ADDR_W (ADDR_W)
    ) u_replay (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_valid),
        .job_empty     (job_empty),
        .job_start     (job_start),
        .job_stop      (len_reg),
        .busy          (busy),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_byte  (payload_byte),
        .empty_event   (empty_event),
        .last_of_event (last_of_event)
    );

endmodule

// ----- hdl/sdle_ram.sv -----
// ---------------------------------------------------------------------------
// SDLE generic RAM
// Single write port, single read port, read data registered.
// ---------------------------------------------------------------------------
module sdle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/sdle_replay.sv -----
// ---------------------------------------------------------------------------
// SDLE payload replay engine
// Reads a finished payload back out of the line store and queues the results.
// ---------------------------------------------------------------------------
module sdle_replay #(
    parameter int LEN_W  = 6,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    // Job from the line capture logic.
    input  logic              job_valid,
    input  logic              job_empty,
    input  logic [LEN_W-1:0]  job_start,
    input  logic [LEN_W-1:0]  job_stop,
    output logic              busy,
    // Read port of the line store.
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    // Result channel.
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        payload_byte,
    output logic              empty_event,
    output logic              last_of_event
);
    import sdle_pkg::*;

    logic             active_reg,        active_next;
    logic             empty_reg,         empty_next;
    logic [LEN_W-1:0] ptr_reg,           ptr_next;
    logic [LEN_W-1:0] stop_reg,          stop_next;
    logic             inflight_reg,      inflight_next;
    logic             inflight_last_reg, inflight_last_next;
    logic             q_wr_reg,          q_wr_next;
    logic             q_rd_reg,          q_rd_next;
    logic [1:0]       cnt_reg,           cnt_next;
    result_t          q_reg [2];

    logic       pop;
    logic       push;
    logic       credit;
    logic       issue_read;
    logic       push_empty;
    logic       read_last;
    logic [1:0] occ;
    result_t    push_val;

    // Queue slots: two, counting a read still in flight.
    assign pop    = (cnt_reg != 2'd0) && !out_stall;
    assign occ    = cnt_reg + {1'b0, inflight_reg};
    assign credit = (occ < 2'd2) || pop;

    // Read issue and the empty-event push, both gated by queue space.
    assign issue_read = active_reg && !empty_reg && credit;
    assign push_empty = active_reg && empty_reg && credit && !inflight_reg;
    assign read_last  = (ptr_reg + LEN_W'(1)) == stop_reg;

    assign rd_en   = issue_read;
    assign rd_addr = ptr_reg[ADDR_W-1:0];
    assign busy    = active_reg;

    // Queue entry source: returning store data or the empty-event marker.
    assign push = inflight_reg || push_empty;
    always_comb
    begin
        if (inflight_reg)
        begin
            push_val.payload_byte  = rd_data;
            push_val.empty_event   = 1'b0;
            push_val.last_of_event = inflight_last_reg;
        end
        else
        begin
            push_val.payload_byte  = 8'd0;
            push_val.empty_event   = 1'b1;
            push_val.last_of_event = 1'b1;
        end
    end

    // Sequencer and queue pointer next state.
    always_comb
    begin
        active_next        = active_reg;
        empty_next         = empty_reg;
        ptr_next           = ptr_reg;
        stop_next          = stop_reg;
        inflight_next      = issue_read;
        inflight_last_next = read_last;
        q_wr_next          = push ? ~q_wr_reg : q_wr_reg;
        q_rd_next          = pop ? ~q_rd_reg : q_rd_reg;
        cnt_next           = cnt_reg + {1'b0, push} - {1'b0, pop};

        if (job_valid && !active_reg)
        begin
            active_next = 1'b1;
            empty_next  = job_empty;
            ptr_next    = job_start;
            stop_next   = job_stop;
        end
        else if (issue_read)
        begin
            ptr_next = ptr_reg + LEN_W'(1);
            if (read_last)
            begin
                active_next = 1'b0;
            end
        end
        else if (push_empty)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= 1'b0;
            empty_reg         <= 1'b0;
            ptr_reg           <= '0;
            stop_reg          <= '0;
            inflight_reg      <= 1'b0;
            inflight_last_reg <= 1'b0;
            q_wr_reg          <= 1'b0;
            q_rd_reg          <= 1'b0;
            cnt_reg           <= 2'd0;
        end
        else
        begin
            active_reg        <= active_next;
            empty_reg         <= empty_next;
            ptr_reg           <= ptr_next;
            stop_reg          <= stop_next;
            inflight_reg      <= inflight_next;
            inflight_last_reg <= inflight_last_next;
            q_wr_reg          <= q_wr_next;
            q_rd_reg          <= q_rd_next;
            cnt_reg           <= cnt_next;
        end
    end

    // Queue storage holds the full result: payload byte and both flags.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[q_wr_reg] <= push_val;
        end
    end

    assign out_valid     = cnt_reg != 2'd0;
    assign payload_byte  = q_reg[q_rd_reg].payload_byte;
    assign empty_event   = q_reg[q_rd_reg].empty_event;
    assign last_of_event = q_reg[q_rd_reg].last_of_event;

endmodule

// ----- hdl/sdle_checker.sv -----
// ---------------------------------------------------------------------------
// SDLE port checker
// Watches the top-level ports and flags behavior the block must never show.
// ---------------------------------------------------------------------------
`include "sse_data_line_extractor_assert.svh"

module sdle_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] payload_byte,
    input logic       empty_event,
    input logic       last_of_event
);
    import sdle_pkg::*;

    // A stalled result holds until taken.
    `SDLE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(payload_byte) && $stable(empty_event) && $stable(last_of_event), "stalled result changed")

    // An empty event is a single, zero-valued, final result.
    `SDLE_ASSERT_IMP(a_empty_form, out_valid && empty_event, last_of_event && (payload_byte == 8'd0), "malformed empty event")

    // Only a terminator can start a replay, so a plain byte never stalls input.
    `SDLE_ASSERT_NXT(a_plain_no_stall, in_valid && !in_stall && (in_byte != BYTE_LF) && (in_byte != BYTE_CR), !in_stall, "input stalled after a plain byte")

endmodule

bind sse_data_line_extractor sdle_checker u_sdle_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SSE data line extractor testbench
// Feeds a byte stream of event lines, including data lines, other fields,
// broken prefixes and store overflows. Each payload result is checked against
// a line parser kept in step with the accepted requests.
// ---------------------------------------------------------------------------
module tb;

    import sdle_pkg::*;

    localparam int LINE_CAP       = LINE_CAP_DEF;
    localparam int RANDOM_ITEMS   = 440;
    localparam int IDLE_PERCENT   = 19;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int BACKLOG_AT     = 120;
    localparam int BACKLOG_CYCLES = 400;
    localparam int DRAIN_CYCLES   = LINE_CAP + 16;
    localparam logic [39:0] DATA_TAG = "data:";

    // How a directed row gets its expected results.
    typedef enum logic [1:0] {
        CHECK_MODEL,
        CHECK_NOTHING,
        CHECK_EMPTY_EVENT
    } row_check_e;

    typedef struct {
        logic [7:0] data;
        row_check_e check;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 26;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] payload_byte;
    logic       empty_event;
    logic       last_of_event;

    // Parser state mirrored from the accepted requests.
    logic [7:0] line_bytes [LINE_CAP - 1];
    int         line_fill;

    result_t    pending_payload [$];
    stim_row_t  directed_rows [DIRECTED_ROWS];
    logic [7:0] line_q [$];

    int         bytes_accepted;
    int         mismatch_count;
    int         quiet_cycles;
    int         backlog_left;
    bit         backlog_done;
    bit         steady_run;

    sse_data_line_extractor #(
        .LINE_CAP(LINE_CAP)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_byte(in_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .payload_byte(payload_byte),
        .empty_event(empty_event),
        .last_of_event(last_of_event)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Advance the line parser by one byte and collect the payload results it emits.
    function automatic void parse_stream_byte(input logic [7:0] b, output result_t produced[$]);
        int  first;
        bit  is_data;
        produced = {};
        if (b == BYTE_LF || b == BYTE_CR)
        begin
            is_data = 1'b0;
            if (line_fill >= PREFIX_LEN)
                is_data = ({line_bytes[0], line_bytes[1], line_bytes[2],
                            line_bytes[3], line_bytes[4]} == DATA_TAG);
            if (is_data)
            begin
                first = PREFIX_LEN;
                if (line_fill > PREFIX_LEN && line_bytes[PREFIX_LEN] == BYTE_SPACE)
                    first = PREFIX_LEN + 1;
                if (first >= line_fill)
                    produced.push_back('{8'h00, 1'b1, 1'b1});
                else
                    for (int i = first; i < line_fill; i++)
                        produced.push_back('{line_bytes[i], 1'b0, (i + 1 == line_fill)});
            end
            line_fill = 0;
        end
        else if (line_fill + 1 >= LINE_CAP)
        begin
            // A byte arriving on a full store flushes the line and is lost.
            line_fill = 0;
        end
        else
        begin
            line_bytes[line_fill] = b;
            line_fill++;
        end
    endfunction

    // Random idle decision shared by both sides.
    function automatic bit idle_roll();
        return !steady_run && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    // Any stream byte other than a line terminator.
    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (v == BYTE_LF || v == BYTE_CR)
            v = v ^ 8'h40;
        return v;
    endfunction

    // Offer one byte, wait for it to be taken and queue what it should produce.
    // Called and returns at a falling edge.
    task automatic send_byte(input logic [7:0] b, input row_check_e check);
        result_t produced [$];
        while (idle_roll())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_accepted++;
        parse_stream_byte(b, produced);
        case (check)
            CHECK_MODEL:       pending_payload = {pending_payload, produced};
            CHECK_EMPTY_EVENT: pending_payload.push_back('{8'h00, 1'b1, 1'b1});
            default:           ;
        endcase
        @(negedge clk);
    endtask

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_payload.size() == 0)
            begin
                $error("unexpected result: payload_byte %0h empty_event %0b last_of_event %0b",
                       payload_byte, empty_event, last_of_event);
                mismatch_count++;
            end
            else
            begin
                want = pending_payload.pop_front();
                if (payload_byte !== want.payload_byte)
                begin
                    $error("payload_byte: expected %0h, got %0h", want.payload_byte, payload_byte);
                    mismatch_count++;
                end
                if (empty_event !== want.empty_event)
                begin
                    $error("empty_event: expected %0b, got %0b", want.empty_event, empty_event);
                    mismatch_count++;
                end
                if (last_of_event !== want.last_of_event)
                begin
                    $error("last_of_event: expected %0b, got %0b",
                           want.last_of_event, last_of_event);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs up the block.
    initial
    begin
        out_stall    = 1'b0;
        backlog_left = 0;
        backlog_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (backlog_left > 0)
            begin
                out_stall <= 1'b1;
                backlog_left--;
            end
            else if (!backlog_done && bytes_accepted >= BACKLOG_AT)
            begin
                backlog_done = 1'b1;
                backlog_left = BACKLOG_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= idle_roll();
            end
        end
    end

    // Main sequence: reset, directed table, random lines, drain.
    initial
    begin
        int shape;
        int body_len;
        int lead;
        int line_no;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_byte        = 8'h00;
        line_fill      = 0;
        bytes_accepted = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        steady_run     = 1'b0;

        // Empty data line, data line with one space then CR LF, extreme bytes, short line.
        directed_rows = '{
            '{8'h64, CHECK_NOTHING}, '{8'h61, CHECK_NOTHING}, '{8'h74, CHECK_NOTHING},
            '{8'h61, CHECK_NOTHING}, '{8'h3a, CHECK_NOTHING}, '{BYTE_LF, CHECK_EMPTY_EVENT},
            '{8'h64, CHECK_NOTHING}, '{8'h61, CHECK_NOTHING}, '{8'h74, CHECK_NOTHING},
            '{8'h61, CHECK_NOTHING}, '{8'h3a, CHECK_NOTHING}, '{BYTE_SPACE, CHECK_NOTHING},
            '{BYTE_CR, CHECK_EMPTY_EVENT}, '{BYTE_LF, CHECK_NOTHING},
            '{8'h64, CHECK_NOTHING}, '{8'h61, CHECK_NOTHING}, '{8'h74, CHECK_NOTHING},
            '{8'h61, CHECK_NOTHING}, '{8'h3a, CHECK_NOTHING}, '{8'h00, CHECK_NOTHING},
            '{8'hff, CHECK_NOTHING}, '{BYTE_LF, CHECK_MODEL},
            '{8'h64, CHECK_NOTHING}, '{8'h61, CHECK_NOTHING}, '{8'h74, CHECK_NOTHING},
            '{BYTE_CR, CHECK_NOTHING}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_byte(directed_rows[r].data, directed_rows[r].check);

        // Random lines: mostly well-formed data lines, the rest noise.
        line_no = 0;
        while (bytes_accepted < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            steady_run = (bytes_accepted >= 250 && bytes_accepted < 340);
            shape = (line_no < 2) ? 0 : $urandom_range(0, 99);
            line_q = {};
            if (shape < 85)
            begin
                line_q = {8'h64, 8'h61, 8'h74, 8'h61, 8'h3a};
                // The first line fills the store exactly, the second runs past it.
                if (line_no == 0)
                    body_len = LINE_CAP - 1 - PREFIX_LEN;
                else if (line_no == 1)
                    body_len = LINE_CAP;
                else if ($urandom_range(0, 9) == 0)
                    body_len = $urandom_range(50, LINE_CAP + 6);
                else
                    body_len = $urandom_range(0, 12);
                lead = $urandom_range(0, 9);
                if (line_no != 0 && lead >= 5)
                    line_q.push_back(BYTE_SPACE);
                if (line_no != 0 && lead == 9)
                    line_q.push_back(BYTE_SPACE);
                repeat (body_len)
                    line_q.push_back(plain_byte());
                // Some lines carry another field or a damaged prefix.
                if (shape >= 70)
                    line_q[$urandom_range(0, PREFIX_LEN - 1)] = plain_byte();
            end
            else if (shape < 95)
            begin
                repeat ($urandom_range(0, 12))
                    line_q.push_back(plain_byte());
            end

            case ($urandom_range(0, 2))
                0:       line_q.push_back(BYTE_LF);
                1:       line_q.push_back(BYTE_CR);
                default: line_q = {line_q, BYTE_CR, BYTE_LF};
            endcase

            foreach (line_q[k])
                send_byte(line_q[k], CHECK_MODEL);
            line_no++;
        end

        // Drain the remaining results, then allow for a late extra one.
        steady_run = 1'b0;
        in_valid <= 1'b0;
        while (pending_payload.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
